// ===== rtl/jvfc_pkg.sv =====
package jvfc_pkg;

    // field widths
    localparam int ANGLE_BITS = 18;
    localparam int VEL_W      = 24;
    localparam int TORQUE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int THR_W      = 23;
    localparam int SCALE_W    = 15;
    localparam int CFG_W      = 23;
    localparam int CFG_IDX_W  = 3;

    // internal widths: the mean sum and the clamped friction both fit in 28 bits
    localparam int AVG_W  = 28;
    localparam int FRIC_W = 28;
    localparam int MUL_W  = (ANGLE_BITS + 1 > AVG_W) ? ANGLE_BITS + 1 : AVG_W;
    localparam int PROD_W = 2 * MUL_W;

    // angle step to 2^-6 rad/s: times 1000, then round by 2^8
    localparam int RATE_GAIN = 1000;
    localparam int RAW_SHIFT = 8;
    localparam int RAW_HALF  = 1 << (RAW_SHIFT - 1);

    localparam int VEL_MAX = (1 << (VEL_W - 1)) - 1;
    localparam int VEL_MIN = -(1 << (VEL_W - 1));

    // divide by three: bias the sum positive, then multiply by ceil(2^28 / 3)
    localparam int DIV3_SHIFT  = 28;
    localparam int DIV3_MAGIC  = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int VEL_BIAS    = 1 << VEL_W;
    localparam int DIV3_OFFSET = 3 * VEL_BIAS;

    // slope times velocity back to Q4.12
    localparam int SLOPE_SHIFT = 6;
    localparam int SLOPE_HALF  = 1 << (SLOPE_SHIFT - 1);

    // friction bound: beyond it any non-zero scale saturates anyway
    localparam int FRIC_MAX = (1 << (FRIC_W - 1)) - 1;
    localparam int FRIC_MIN = -(1 << (FRIC_W - 1));

    localparam int SCALE_SHIFT  = 12;
    localparam int SCALE_HALF   = 1 << (SCALE_SHIFT - 1);
    localparam int TORQUE_LIMIT = 20480;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_VISCOUS_POS = 3'd1,
        CFG_COULOMB_POS = 3'd2,
        CFG_VISCOUS_NEG = 3'd3,
        CFG_COULOMB_NEG = 3'd4,
        CFG_STATIC      = 3'd5,
        CFG_SCALE       = 3'd6
    } t_cfg_idx;

    // sequencer steps
    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_DIV,
        S_VEL,
        S_SLOPE,
        S_FRIC,
        S_SCALE,
        S_DONE
    } t_state;

    // friction model branch
    typedef enum logic [1:0] {
        REG_STATIC,
        REG_POS,
        REG_NEG
    } t_region;

endpackage

// ===== rtl/joint_velocity_friction_compensator.sv =====
// Joint velocity estimate and friction torque for one robot joint. Each input beat
// is a motor angle sample; each produces exactly one output beat with the filtered
// velocity (2^-6 rad/s) and the scaled, saturated friction torque (Q4.12, +/-5.0).
// One item is in flight at a time; no new sample is taken until its result is loaded:
// a small sequencer runs the angle rate, the divide-by-three of the velocity
// filter, the slope product and the scale product through one shared signed
// multiplier, one product per step, with o_in_stall high throughout. The result
// sits in an output register, so a stalled output delays only the final step.
// Configuration writes take effect immediately and belong in idle periods.
module joint_velocity_friction_compensator (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration
    input  logic                                      i_cfg_we,
    input  logic [jvfc_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [jvfc_pkg::CFG_W-1:0]                i_cfg_data,
    // angle samples
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic signed [jvfc_pkg::ANGLE_BITS-1:0]    i_motor_angle,
    // results
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [jvfc_pkg::VEL_W-1:0]         o_joint_velocity,
    output logic signed [jvfc_pkg::TORQUE_W-1:0]      o_friction_torque
);

    localparam int AB     = jvfc_pkg::ANGLE_BITS;
    localparam int VW     = jvfc_pkg::VEL_W;
    localparam int MW     = jvfc_pkg::MUL_W;
    localparam int PW     = jvfc_pkg::PROD_W;
    localparam int AW     = jvfc_pkg::AVG_W;
    localparam int FW     = jvfc_pkg::FRIC_W;
    localparam int CW     = jvfc_pkg::COEF_W;
    localparam int TW     = jvfc_pkg::TORQUE_W;

    // configuration registers
    logic        [jvfc_pkg::THR_W-1:0]   r_thr;
    logic signed [CW-1:0]                r_visc_pos;
    logic signed [CW-1:0]                r_coul_pos;
    logic signed [CW-1:0]                r_visc_neg;
    logic signed [CW-1:0]                r_coul_neg;
    logic signed [CW-1:0]                r_static;
    logic        [jvfc_pkg::SCALE_W-1:0] r_scale;

    // joint state
    logic signed [AB-1:0] r_prev;
    logic signed [VW-1:0] r_hist1;
    logic signed [VW-1:0] r_hist2;

    // sequencer and working registers
    jvfc_pkg::t_state  r_state;
    jvfc_pkg::t_state  n_state;
    jvfc_pkg::t_region r_region;
    logic signed [AB-1:0] r_angle;
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_vel;
    logic signed [FW-1:0] r_fric;

    // output register
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_vel;
    logic signed [TW-1:0] r_out_tq;

    logic                 in_accept;
    logic                 out_load;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [AB:0]   diff;
    logic signed [PW-1:0] raw_round;
    logic signed [VW-1:0] raw_sat;
    logic signed [AW-1:0] avg_sum;
    logic signed [VW:0]   vel_calc;
    logic signed [VW:0]   thr_pos;
    logic signed [VW:0]   thr_neg;
    logic signed [CW-1:0] slope_sel;
    logic signed [CW-1:0] coul_sel;
    logic signed [PW-1:0] fric_full;
    logic signed [FW-1:0] fric_sat;
    logic signed [PW-1:0] tq_full;
    logic signed [TW-1:0] tq_sat;

    assign in_accept = i_in_valid && (r_state == jvfc_pkg::S_IDLE);
    assign o_in_stall = (r_state != jvfc_pkg::S_IDLE);

    // shared multiplier
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // angle step, full width
    assign diff = (AB + 1)'(r_angle) - (AB + 1)'(r_prev);

    // raw velocity, rounded and saturated
    assign raw_round = (r_prod + PW'(jvfc_pkg::RAW_HALF)) >>> jvfc_pkg::RAW_SHIFT;
    always_comb begin
        if (raw_round > PW'(jvfc_pkg::VEL_MAX)) begin
            raw_sat = VW'(jvfc_pkg::VEL_MAX);
        end else if (raw_round < PW'(jvfc_pkg::VEL_MIN)) begin
            raw_sat = VW'(jvfc_pkg::VEL_MIN);
        end else begin
            raw_sat = raw_round[VW-1:0];
        end
    end

    // three-term sum, biased positive for the reciprocal divide
    assign avg_sum = AW'(raw_sat) + AW'(r_hist1) + AW'(r_hist2)
                   + AW'(jvfc_pkg::DIV3_OFFSET + 1);

    // filtered velocity with the bias removed
    assign vel_calc = (VW + 1)'(r_prod >>> jvfc_pkg::DIV3_SHIFT)
                    - (VW + 1)'(jvfc_pkg::VEL_BIAS);

    assign thr_pos = {2'b00, r_thr};
    assign thr_neg = -thr_pos;

    // coefficients of the chosen branch
    always_comb begin
        case (r_region)
            jvfc_pkg::REG_POS: begin
                slope_sel = r_visc_pos;
                coul_sel  = r_coul_pos;
            end
            jvfc_pkg::REG_NEG: begin
                slope_sel = r_visc_neg;
                coul_sel  = r_coul_neg;
            end
            default: begin
                slope_sel = r_static;
                coul_sel  = '0;
            end
        endcase
    end

    // friction before scaling, bounded to the working width
    assign fric_full = ((r_prod + PW'(jvfc_pkg::SLOPE_HALF)) >>> jvfc_pkg::SLOPE_SHIFT)
                     + PW'(coul_sel);
    always_comb begin
        if (fric_full > PW'(jvfc_pkg::FRIC_MAX)) begin
            fric_sat = FW'(jvfc_pkg::FRIC_MAX);
        end else if (fric_full < PW'(jvfc_pkg::FRIC_MIN)) begin
            fric_sat = FW'(jvfc_pkg::FRIC_MIN);
        end else begin
            fric_sat = fric_full[FW-1:0];
        end
    end

    // scaled torque, saturated
    assign tq_full = (r_prod + PW'(jvfc_pkg::SCALE_HALF)) >>> jvfc_pkg::SCALE_SHIFT;
    always_comb begin
        if (tq_full > PW'(jvfc_pkg::TORQUE_LIMIT)) begin
            tq_sat = TW'(jvfc_pkg::TORQUE_LIMIT);
        end else if (tq_full < -PW'(jvfc_pkg::TORQUE_LIMIT)) begin
            tq_sat = -TW'(jvfc_pkg::TORQUE_LIMIT);
        end else begin
            tq_sat = tq_full[TW-1:0];
        end
    end

    // sequencer: next step and multiplier operands
    always_comb begin
        n_state  = r_state;
        mul_a    = '0;
        mul_b    = '0;
        out_load = 1'b0;
        case (r_state)
            jvfc_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = jvfc_pkg::S_RATE;
                end
            end
            jvfc_pkg::S_RATE: begin
                mul_a   = MW'(diff);
                mul_b   = MW'(jvfc_pkg::RATE_GAIN);
                n_state = jvfc_pkg::S_DIV;
            end
            jvfc_pkg::S_DIV: begin
                mul_a   = MW'(avg_sum);
                mul_b   = MW'(jvfc_pkg::DIV3_MAGIC);
                n_state = jvfc_pkg::S_VEL;
            end
            jvfc_pkg::S_VEL: begin
                n_state = jvfc_pkg::S_SLOPE;
            end
            jvfc_pkg::S_SLOPE: begin
                mul_a   = MW'(r_vel);
                mul_b   = MW'(slope_sel);
                n_state = jvfc_pkg::S_FRIC;
            end
            jvfc_pkg::S_FRIC: begin
                n_state = jvfc_pkg::S_SCALE;
            end
            jvfc_pkg::S_SCALE: begin
                mul_a   = MW'(r_fric);
                mul_b   = MW'({1'b0, r_scale});
                n_state = jvfc_pkg::S_DONE;
            end
            jvfc_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = jvfc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jvfc_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jvfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= jvfc_pkg::THR_W'(6);
            r_visc_pos <= '0;
            r_coul_pos <= '0;
            r_visc_neg <= '0;
            r_coul_neg <= '0;
            r_static   <= '0;
            r_scale    <= jvfc_pkg::SCALE_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jvfc_pkg::CFG_THRESHOLD:   r_thr      <= i_cfg_data[jvfc_pkg::THR_W-1:0];
                jvfc_pkg::CFG_VISCOUS_POS: r_visc_pos <= i_cfg_data[CW-1:0];
                jvfc_pkg::CFG_COULOMB_POS: r_coul_pos <= i_cfg_data[CW-1:0];
                jvfc_pkg::CFG_VISCOUS_NEG: r_visc_neg <= i_cfg_data[CW-1:0];
                jvfc_pkg::CFG_COULOMB_NEG: r_coul_neg <= i_cfg_data[CW-1:0];
                jvfc_pkg::CFG_STATIC:      r_static   <= i_cfg_data[CW-1:0];
                jvfc_pkg::CFG_SCALE:       r_scale    <= i_cfg_data[jvfc_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_angle <= i_motor_angle;
        end
        if (r_state == jvfc_pkg::S_RATE || r_state == jvfc_pkg::S_DIV
            || r_state == jvfc_pkg::S_SLOPE || r_state == jvfc_pkg::S_SCALE) begin
            r_prod <= mul_p;
        end
        if (r_state == jvfc_pkg::S_VEL) begin
            r_vel <= vel_calc[VW-1:0];
            if (vel_calc > thr_pos) begin
                r_region <= jvfc_pkg::REG_POS;
            end else if (vel_calc < thr_neg) begin
                r_region <= jvfc_pkg::REG_NEG;
            end else begin
                r_region <= jvfc_pkg::REG_STATIC;
            end
        end
        if (r_state == jvfc_pkg::S_FRIC) begin
            r_fric <= fric_sat;
        end
    end

    // joint history, updated as the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_hist1 <= '0;
            r_hist2 <= '0;
        end else if (out_load) begin
            r_prev  <= r_angle;
            r_hist1 <= r_vel;
            r_hist2 <= r_hist1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vel <= r_vel;
            r_out_tq  <= tq_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_joint_velocity  = r_out_vel;
    assign o_friction_torque = r_out_tq;

endmodule

// ===== rtl/jvfc_checker.sv =====
module jvfc_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [jvfc_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [jvfc_pkg::CFG_W-1:0]                i_cfg_data,
    input  logic                                      i_in_valid,
    input  logic                                      o_in_stall,
    input  logic signed [jvfc_pkg::ANGLE_BITS-1:0]    i_motor_angle,
    input  logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [jvfc_pkg::VEL_W-1:0]         o_joint_velocity,
    input  logic signed [jvfc_pkg::TORQUE_W-1:0]      o_friction_torque
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_joint_velocity)
            && $stable(o_friction_torque))
        else $error("result beat changed while stalled");

    // an accepted sample makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no busy period after an accepted sample");

    // a new result only follows a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");

    // torque stays within the saturation limits
    a_torque_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_friction_torque <= 16'sd20480)
            && (o_friction_torque >= -16'sd20480))
        else $error("friction torque outside limits");

endmodule

bind joint_velocity_friction_compensator jvfc_checker u_jvfc_checker (.*);

// ===== dv/joint_velocity_friction_compensator_tb.sv =====
module joint_velocity_friction_compensator_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 100;

    // index with no register behind it
    localparam logic [jvfc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // angle extremes
    localparam logic signed [jvfc_pkg::ANGLE_BITS-1:0] ANGLE_MAX =
        {1'b0, {(jvfc_pkg::ANGLE_BITS-1){1'b1}}};
    localparam logic signed [jvfc_pkg::ANGLE_BITS-1:0] ANGLE_MIN =
        {1'b1, {(jvfc_pkg::ANGLE_BITS-1){1'b0}}};

    localparam longint RATE_MUL   = 1000;
    localparam longint VEL_LO     = -8388608;
    localparam longint VEL_HI     = 8388607;
    localparam longint TORQUE_SAT = 20480;

    typedef struct {
        logic signed [jvfc_pkg::VEL_W-1:0]    vel;
        logic signed [jvfc_pkg::TORQUE_W-1:0] torque;
    } t_joint_result;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   i_cfg_we;
    logic [jvfc_pkg::CFG_IDX_W-1:0]         i_cfg_index;
    logic [jvfc_pkg::CFG_W-1:0]             i_cfg_data;
    logic                                   i_in_valid;
    logic                                   o_in_stall;
    logic signed [jvfc_pkg::ANGLE_BITS-1:0] i_motor_angle;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic signed [jvfc_pkg::VEL_W-1:0]      o_joint_velocity;
    logic signed [jvfc_pkg::TORQUE_W-1:0]   o_friction_torque;

    t_joint_result pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            stall_left     = 0;
    int            in_gap_max     = 0;
    int            out_gap_max    = 0;

    // predictor copy of the registers
    longint cfg_threshold, cfg_visc_pos, cfg_coul_pos, cfg_visc_neg;
    longint cfg_coul_neg, cfg_static, cfg_scale;
    // predictor copy of the joint state
    longint st_prev_angle, st_vel_one, st_vel_two;

    joint_velocity_friction_compensator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_motor_angle     (i_motor_angle),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_joint_velocity  (o_joint_velocity),
        .o_friction_torque (o_friction_torque)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint round_down_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint saturate(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // floor division by three, also for negative sums
    function automatic longint floor_third(longint x);
        longint q;
        q = x / 3;
        if (x % 3 < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic void reset_predictor();
        cfg_threshold = 6;
        cfg_visc_pos  = 0;
        cfg_coul_pos  = 0;
        cfg_visc_neg  = 0;
        cfg_coul_neg  = 0;
        cfg_static    = 0;
        cfg_scale     = 4096;
        st_prev_angle = 0;
        st_vel_one    = 0;
        st_vel_two    = 0;
    endfunction

    // velocity filter and friction law for one angle sample
    task automatic estimate_joint_sample(
        input logic signed [jvfc_pkg::ANGLE_BITS-1:0] angle,
        output t_joint_result res);
        longint ang, raw, vel, fric, trq;
        ang = angle;
        raw = saturate(round_down_shift((ang - st_prev_angle) * RATE_MUL, 8), VEL_LO, VEL_HI);
        vel = floor_third(raw + st_vel_one + st_vel_two + 1);
        if (vel > cfg_threshold)
            fric = round_down_shift(cfg_visc_pos * vel, 6) + cfg_coul_pos;
        else if (vel < -cfg_threshold)
            fric = round_down_shift(cfg_visc_neg * vel, 6) + cfg_coul_neg;
        else
            fric = round_down_shift(cfg_static * vel, 6);
        trq = saturate(round_down_shift(fric * cfg_scale, 12), -TORQUE_SAT, TORQUE_SAT);
        st_prev_angle = ang;
        st_vel_two    = st_vel_one;
        st_vel_one    = vel;
        res.vel       = vel[jvfc_pkg::VEL_W-1:0];
        res.torque    = trq[jvfc_pkg::TORQUE_W-1:0];
    endtask

    // ---------------------------------------------------------------- drivers

    // register write while the block is idle
    task automatic write_reg(input logic [jvfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jvfc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            jvfc_pkg::CFG_THRESHOLD:
                cfg_threshold = longint'(data[jvfc_pkg::THR_W-1:0]);
            jvfc_pkg::CFG_VISCOUS_POS:
                cfg_visc_pos  = longint'(signed'(data[jvfc_pkg::COEF_W-1:0]));
            jvfc_pkg::CFG_COULOMB_POS:
                cfg_coul_pos  = longint'(signed'(data[jvfc_pkg::COEF_W-1:0]));
            jvfc_pkg::CFG_VISCOUS_NEG:
                cfg_visc_neg  = longint'(signed'(data[jvfc_pkg::COEF_W-1:0]));
            jvfc_pkg::CFG_COULOMB_NEG:
                cfg_coul_neg  = longint'(signed'(data[jvfc_pkg::COEF_W-1:0]));
            jvfc_pkg::CFG_STATIC:
                cfg_static    = longint'(signed'(data[jvfc_pkg::COEF_W-1:0]));
            jvfc_pkg::CFG_SCALE:
                cfg_scale     = longint'(data[jvfc_pkg::SCALE_W-1:0]);
            default: ;
        endcase
    endtask

    // one angle beat; returns at the accepting edge
    task automatic send_angle(input logic signed [jvfc_pkg::ANGLE_BITS-1:0] angle);
        int            gap;
        t_joint_result res;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_motor_angle <= angle;
        do @(posedge i_clk); while (o_in_stall);
        estimate_joint_sample(angle, res);
        pending_results.push_back(res);
    endtask

    // drop valid and wait for every result plus the pipeline tail
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void flag_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_joint_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            stall_left = $urandom_range(0, out_gap_max);
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected beat velocity", 0, o_joint_velocity);
            end else begin
                want = pending_results.pop_front();
                if (o_joint_velocity !== want.vel)
                    flag_mismatch("joint_velocity", want.vel, o_joint_velocity);
                if (o_friction_torque !== want.torque)
                    flag_mismatch("friction_torque", want.torque, o_friction_torque);
            end
        end
    end

    // receiver holds off for the drawn number of cycles after each beat
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("joint_velocity_friction_compensator_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // reset values: first sample against zero, angle extremes, full-range steps
    task automatic test_power_on_defaults();
        in_gap_max  = 0;
        out_gap_max = 0;
        send_angle(18'sd0);
        send_angle(18'sd300);
        send_angle(ANGLE_MAX);
        send_angle(ANGLE_MIN);
        send_angle(ANGLE_MIN);
        send_angle(ANGLE_MAX);
        send_angle(18'sd0);
        settle_block();
    endtask

    // static, positive and negative sliding, saturation and zero threshold
    task automatic test_friction_regions();
        in_gap_max  = 15;
        out_gap_max = 15;
        write_reg(jvfc_pkg::CFG_THRESHOLD, 23'd0);
        write_reg(jvfc_pkg::CFG_VISCOUS_POS, 23'd4096);
        write_reg(jvfc_pkg::CFG_COULOMB_POS, 23'd800);
        write_reg(jvfc_pkg::CFG_VISCOUS_NEG, 23'd2048);
        write_reg(jvfc_pkg::CFG_COULOMB_NEG, 23'h7FFCE0);
        write_reg(jvfc_pkg::CFG_STATIC, 23'd1000);
        write_reg(jvfc_pkg::CFG_SCALE, 23'd4096);
        // small steps around zero with a zero threshold: both sliding branches
        send_angle(18'sd0);
        send_angle(18'sd0);
        send_angle(18'sd50);
        send_angle(18'sd100);
        send_angle(18'sd50);
        send_angle(18'sd0);
        settle_block();
        // largest coefficients drive the torque into both limits
        write_reg(jvfc_pkg::CFG_VISCOUS_POS, 23'h7F7FFF);
        write_reg(jvfc_pkg::CFG_COULOMB_POS, 23'h007FFF);
        write_reg(jvfc_pkg::CFG_VISCOUS_NEG, 23'h007FFF);
        write_reg(jvfc_pkg::CFG_COULOMB_NEG, 23'h7F8000);
        write_reg(jvfc_pkg::CFG_SCALE, 23'h7FFFFF);
        send_angle(18'sd60000);
        send_angle(18'sd120000);
        send_angle(-18'sd120000);
        settle_block();
        write_reg(jvfc_pkg::CFG_SCALE, 23'h7F8000);
        write_reg(jvfc_pkg::CFG_THRESHOLD, 23'h7FFFFF);
        write_reg(jvfc_pkg::CFG_STATIC, 23'h7F8000);
        send_angle(18'sd0);
        settle_block();
        write_reg(jvfc_pkg::CFG_SCALE, 23'd4096);
        send_angle(18'sd400);
        settle_block();
    endtask

    // a write to the spare index leaves every register alone
    task automatic test_unused_register();
        write_reg(CFG_UNUSED, 23'h7FFFFF);
        send_angle(-18'sd300);
        send_angle(18'sd1);
        settle_block();
    endtask

    function automatic logic [jvfc_pkg::CFG_W-1:0] coef_word(int phase);
        logic [jvfc_pkg::CFG_W-1:0] w;
        w = jvfc_pkg::CFG_W'($urandom);
        if (phase == 0)
            w[jvfc_pkg::COEF_W-1:0] = 16'h8000;
        else if (phase == 1)
            w[jvfc_pkg::COEF_W-1:0] = 16'h7FFF;
        else if ($urandom_range(0, 3) == 0)
            w[jvfc_pkg::COEF_W-1:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        return w;
    endfunction

    // random settings, then motion legs at steady speed with jitter and noise
    task automatic test_random_motion();
        logic [jvfc_pkg::CFG_W-1:0]             w;
        logic signed [jvfc_pkg::ANGLE_BITS-1:0] angle;
        int                                     speed, vstep, leg_left;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            speed = $urandom_range(1, 800);
            // threshold around the typical filtered speed, extremes now and then
            case (phase)
                0:       w = '0;
                1:       w = 23'h7FFFFF;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       w = '0;
                        1:       w = jvfc_pkg::CFG_W'($urandom);
                        default: w = jvfc_pkg::CFG_W'($urandom_range(0, 4 * speed));
                    endcase
                end
            endcase
            write_reg(jvfc_pkg::CFG_THRESHOLD, w);
            write_reg(jvfc_pkg::CFG_VISCOUS_POS, coef_word(phase));
            write_reg(jvfc_pkg::CFG_COULOMB_POS, coef_word(phase));
            write_reg(jvfc_pkg::CFG_VISCOUS_NEG, coef_word(phase));
            write_reg(jvfc_pkg::CFG_COULOMB_NEG, coef_word(phase));
            write_reg(jvfc_pkg::CFG_STATIC, coef_word(phase));
            w = jvfc_pkg::CFG_W'($urandom);
            if (phase == 0)
                w[jvfc_pkg::SCALE_W-1:0] = '0;
            else if (phase == 1)
                w[jvfc_pkg::SCALE_W-1:0] = 15'h7FFF;
            else if ($urandom_range(0, 1) == 0)
                w[jvfc_pkg::SCALE_W-1:0] = jvfc_pkg::SCALE_W'($urandom_range(0, 8191));
            write_reg(jvfc_pkg::CFG_SCALE, w);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, jvfc_pkg::CFG_W'($urandom));

            in_gap_max  = (phase % 3 == 0) ? 0 : 15;
            out_gap_max = (phase % 4 == 1) ? 0 : 15;
            angle    = jvfc_pkg::ANGLE_BITS'($urandom);
            leg_left = 0;
            vstep    = 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (leg_left == 0) begin
                    leg_left = $urandom_range(5, 30);
                    vstep    = int'($urandom_range(0, 2 * speed)) - speed;
                end
                leg_left--;
                if ($urandom_range(0, 9) == 0)
                    angle = jvfc_pkg::ANGLE_BITS'($urandom);
                else
                    angle = jvfc_pkg::ANGLE_BITS'(angle + vstep
                                                  + int'($urandom_range(0, 6)) - 3);
                send_angle(angle);
            end
            settle_block();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_motor_angle = '0;
        reset_predictor();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_friction_regions();
        test_unused_register();
        test_random_motion();
        settle_block();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("joint_velocity_friction_compensator_tb: PASS");
        else
            $display("joint_velocity_friction_compensator_tb: FAIL");
        $finish;
    end

endmodule
